// File: hw/rtl/pir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pir_pkg: shared definitions for the polled input change reporter
// Widths, register indexes, item and report types and the saturating time
// adder used by the channel walker.
// ----------------------------------------------------------------------------
package pir_pkg;

   // Sizes of the channel table, the pin word and the time base.
   localparam int CHANNELS    = 32;
   localparam int CHAN_BITS   = 5;
   localparam int CNT_BITS    = 6;
   localparam int PIN_COUNT   = 64;
   localparam int PIN_BITS    = 6;
   localparam int TIME_BITS   = 40;
   localparam int PERIOD_BITS = 24;

   // Pins at or above the pin count read as zero.
   localparam logic [63:0] PIN_MASK =
      (PIN_COUNT >= 64) ? {64{1'b1}} : ((64'd1 << PIN_COUNT) - 64'd1);

   // Request word layout, lowest field first.
   localparam int REQ_TDATA_BITS = 144;
   localparam int RQ_NOW_LO      = 0;
   localparam int RQ_PINS_LO     = 40;
   localparam int RQ_IDX_LO      = 104;
   localparam int RQ_SEL_LO      = 109;
   localparam int RQ_INV_LO      = 115;
   localparam int RQ_PER_LO      = 116;

   // Response word layout, lowest field first.
   localparam int RSP_TDATA_BITS = 16;

   // Command codes carried on req_tuser.
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_CONFIG = 1'b1;

   // Control register indexes.
   localparam int  CSR_ADDR_BITS     = 1;
   localparam logic CSR_REPORT_PERIOD = 1'b0;
   localparam logic CSR_CHANNEL_COUNT = 1'b1;
   localparam logic [PERIOD_BITS-1:0] REPORT_PERIOD_RESET = 24'd300;

   // One classified request word as handed from front to back.
   typedef struct packed {
      logic                   is_config;
      logic [TIME_BITS-1:0]   now_ms;
      logic [63:0]            pin_levels;
      logic [CHAN_BITS-1:0]   channel_index;
      logic [PIN_BITS-1:0]    pin_select;
      logic                   invert_bit;
      logic [PERIOD_BITS-1:0] period_ms;
   } item_type;

   // One report word.
   typedef struct packed {
      logic                 last_report;
      logic                 report_level;
      logic [PIN_BITS-1:0]  report_pin;
      logic [CHAN_BITS-1:0] report_channel;
   } report_type;

   // Add two times and clamp at the all-ones maximum.
   function automatic logic [TIME_BITS-1:0] time_add_sat(
      input logic [TIME_BITS-1:0] a,
      input logic [TIME_BITS-1:0] b
   );
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/polled_input_change_reporter.sv
`default_nettype none
// A request word is registered in the front queue before the walker sees it.
// A configure item is executed as it is popped. A tick steps through a pop,
// the full-report check, a step for each active channel, a step to see the
// walk end and a close; a full output queue stalls the walk and the close.
// Up to two request words and two reports are queued; one more is held back.
// Reset is synchronous and active high; the first tick reports every channel.
// ----------------------------------------------------------------------------
// polled_input_change_reporter: top level
// Polls configured input channels on each time tick and reports channels
// whose level changed, with a periodic full report.
// ----------------------------------------------------------------------------
module polled_input_change_reporter
   import pir_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire [CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire [PERIOD_BITS-1:0]      csr_wdata,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // now_ms, pin_levels, channel_index, channel_pin_select,
   // channel_invert_bit, channel_period_ms, zero pad
   input  wire [REQ_TDATA_BITS-1:0]   req_tdata,
   // command
   input  wire                        req_tuser,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // report_channel, report_pin, report_level, zero pad
   output logic [RSP_TDATA_BITS-1:0]  rsp_tdata,
   output logic                       rsp_tlast
);

   item_type   item;
   logic       item_valid, item_ready;
   report_type report;

   // Request intake and queue.
   pir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // Channel table, walker and output queue.
   pir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_report (report)
   );

   // Pack the report word.
   assign rsp_tdata = {4'b0000, report.report_level, report.report_pin,
                       report.report_channel};
   assign rsp_tlast = report.last_report;

endmodule
`default_nettype wire

// File: hw/rtl/pir_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pir_front: request intake
// Accepts request words, decodes them into tick or configure items and holds
// them in a two-entry queue for the channel walker.
// ----------------------------------------------------------------------------
module pir_front
   import pir_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // now_ms, pin_levels, channel_index, channel_pin_select,
   // channel_invert_bit, channel_period_ms, zero pad
   input  wire [REQ_TDATA_BITS-1:0]   req_tdata,
   // command
   input  wire                        req_tuser,
   output logic                       item_valid,
   input  wire                        item_ready,
   output item_type                   item
);

   item_type   queue_ff [2];
   item_type   decoded;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // Split the request word into its fields.
   always_comb begin
      decoded.is_config     = (req_tuser == CMD_CONFIG);
      decoded.now_ms        = req_tdata[RQ_NOW_LO +: TIME_BITS];
      decoded.pin_levels    = req_tdata[RQ_PINS_LO +: 64];
      decoded.channel_index = req_tdata[RQ_IDX_LO +: CHAN_BITS];
      decoded.pin_select    = req_tdata[RQ_SEL_LO +: PIN_BITS];
      decoded.invert_bit    = req_tdata[RQ_INV_LO];
      decoded.period_ms     = req_tdata[RQ_PER_LO +: PERIOD_BITS];
   end

   // Queue bookkeeping.
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid & req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_valid & item_ready;
   assign item       = queue_ff[rd_ptr_ff];
   assign wr_ptr_in  = wr_ptr_ff ^ push;
   assign rd_ptr_in  = rd_ptr_ff ^ pop;
   assign count_in   = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/pir_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pir_back: channel table and walker
// Executes configure items, runs the full-report check and walks the active
// channels one per cycle while the two-entry output queue has space, holding
// back one report to flag the final one of a tick, and buffers reports there.
// ----------------------------------------------------------------------------
module pir_back
   import pir_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire [CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire [PERIOD_BITS-1:0]      csr_wdata,
   input  wire                        item_valid,
   output logic                       item_ready,
   input  item_type                   item,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output report_type                 rsp_report
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_WALK  = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic                   force_ff, force_in;
   logic [TIME_BITS-1:0]   last_full_ff, last_full_in;
   logic [TIME_BITS-1:0]   now_ff;
   logic [63:0]            pins_ff;
   logic [PERIOD_BITS-1:0] report_period_ff;
   logic [CNT_BITS-1:0]    channel_count_ff;
   report_type             held_ff, held_in;
   logic                   held_valid_ff, held_valid_in;

   // Channel table.
   logic [PIN_BITS-1:0]    pin_ff      [CHANNELS];
   logic                   invert_ff   [CHANNELS];
   logic [PERIOD_BITS-1:0] period_ff   [CHANNELS];
   logic [TIME_BITS-1:0]   deadline_ff [CHANNELS];
   logic                   level_ff    [CHANNELS];
   logic                   known_ff    [CHANNELS];

   // Output queue.
   report_type             outq_ff [2];
   logic                   owr_ptr_ff, ord_ptr_ff;
   logic [1:0]             ocount_ff, ocount_in;
   logic                   push, pop, out_space;
   report_type             push_data;

   logic                   tick_load, cfg_we, ent_we;
   logic [CNT_BITS-1:0]    active;
   logic [CHAN_BITS-1:0]   ch;
   logic [PIN_BITS-1:0]    rd_pin;
   logic                   rd_level_now, due, known_eff, emit;
   logic [TIME_BITS-1:0]   new_deadline;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         report_period_ff <= REPORT_PERIOD_RESET;
         channel_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_REPORT_PERIOD: report_period_ff <= csr_wdata;
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign active = (channel_count_ff > CNT_BITS'(CHANNELS)) ? CNT_BITS'(CHANNELS)
                                                           : channel_count_ff;

   // Evaluate the channel under the walk pointer.
   assign ch           = idx_ff[CHAN_BITS-1:0];
   assign rd_pin       = pin_ff[ch];
   assign rd_level_now = pins_ff[rd_pin] ^ invert_ff[ch];
   assign due          = (deadline_ff[ch] <= now_ff) || force_ff;
   assign known_eff    = known_ff[ch] & ~force_ff;
   assign emit         = due && (!known_eff || (level_ff[ch] != rd_level_now));
   assign new_deadline = time_add_sat(now_ff, TIME_BITS'(period_ff[ch]));

   assign out_space = (ocount_ff != 2'd2);

   // Walker sequencing.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      force_in      = force_ff;
      last_full_in  = last_full_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      item_ready    = 1'b0;
      push          = 1'b0;
      push_data     = held_ff;
      ent_we        = 1'b0;
      cfg_we        = 1'b0;
      tick_load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               if (item.is_config) begin
                  cfg_we = (32'(item.channel_index) < 32'(CHANNELS));
               end else begin
                  tick_load = 1'b1;
                  state_in  = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (time_add_sat(last_full_ff, TIME_BITS'(report_period_ff)) <= now_ff) begin
               force_in     = 1'b1;
               last_full_in = now_ff;
            end
            idx_in   = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (idx_ff >= active) begin
               state_in = S_FLUSH;
            end else if (out_space) begin
               idx_in = idx_ff + CNT_BITS'(1);
               ent_we = due;
               if (emit) begin
                  held_in.report_channel = ch;
                  held_in.report_pin     = rd_pin;
                  held_in.report_level   = rd_level_now;
                  held_in.last_report    = 1'b0;
                  held_valid_in          = 1'b1;
                  push                   = held_valid_ff;
                  push_data.last_report  = 1'b0;
               end
            end
         end
         S_FLUSH: begin
            if (!held_valid_ff) begin
               force_in = 1'b0;
               state_in = S_IDLE;
            end else if (out_space) begin
               push                  = 1'b1;
               push_data.last_report = 1'b1;
               held_valid_in         = 1'b0;
               force_in              = 1'b0;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         force_ff      <= 1'b1;
         last_full_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         force_ff      <= force_in;
         last_full_ff  <= last_full_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // Tick payload and held report carry no reset.
   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (tick_load) begin
         now_ff  <= item.now_ms;
         pins_ff <= item.pin_levels & PIN_MASK;
      end
   end

   // Channel settings are written only by configure items.
   always_ff @(posedge clock) begin
      if (cfg_we) begin
         pin_ff[item.channel_index]    <= item.pin_select;
         invert_ff[item.channel_index] <= item.invert_bit;
         period_ff[item.channel_index] <= item.period_ms;
      end
   end

   // Channel status: cleared at reset, reloaded by configure and walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            deadline_ff[i] <= '0;
            level_ff[i]    <= 1'b0;
            known_ff[i]    <= 1'b0;
         end
      end else if (cfg_we) begin
         deadline_ff[item.channel_index] <= '0;
         known_ff[item.channel_index]    <= 1'b0;
      end else if (ent_we) begin
         deadline_ff[ch] <= new_deadline;
         if (emit) begin
            level_ff[ch] <= rd_level_now;
            known_ff[ch] <= 1'b1;
         end
      end
   end

   // Output queue.
   assign rsp_valid  = (ocount_ff != 2'd0);
   assign pop        = rsp_valid & rsp_ready;
   assign rsp_report = outq_ff[ord_ptr_ff];
   assign ocount_in  = ocount_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ptr_ff <= 1'b0;
         ord_ptr_ff <= 1'b0;
         ocount_ff  <= 2'd0;
      end else begin
         owr_ptr_ff <= owr_ptr_ff ^ push;
         ord_ptr_ff <= ord_ptr_ff ^ pop;
         ocount_ff  <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         outq_ff[owr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   // No report is held back while no tick is in progress.
   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !held_valid_ff)
      else $error("held report left over outside a tick");

   // The output queue is never pushed when full.
   a_push_space: assert property (@(posedge clock) disable iff (reset)
      push |-> (ocount_ff != 2'd2))
      else $error("output queue overflow");

   // The full-report flag is clear once a tick finishes.
   a_force_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && state_in == S_IDLE) |=> !force_ff)
      else $error("full-report flag survived the tick");

   // A final report always closes a tick.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.last_report) |=> (state_ff == S_IDLE))
      else $error("final report pushed mid-walk");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: polled input change reporter
// Configures channel entries through the request stream and sweeps the two
// control registers over their extremes. Each tick word is checked against a
// local model of the channel walk. A short directed script comes first, with
// some answers typed in. Then random phases follow, with ticks whose time
// mostly moves forward and whose pin words change a few bits at a time. Both
// stream sides stall in random bursts, and the report side holds off once for
// a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pir_pkg::*;

   localparam logic [TIME_BITS-1:0] TIME_LIMIT = {TIME_BITS{1'b1}};
   localparam int SETTLE_CYCLES    = 100;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASES           = 10;
   localparam int WORDS_PER_PHASE  = 38;

   // One expected report, as carried on rsp_tdata and rsp_tlast.
   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic [PIN_BITS-1:0]  pin;
      logic                 level;
      logic                 last;
   } change_report_type;

   typedef enum {ROW_CONFIG, ROW_TICK, ROW_CSR} row_kind_type;

   // One line of the stimulus script.
   typedef struct {
      row_kind_type             kind;
      logic [TIME_BITS-1:0]     now;
      logic [63:0]              pins;
      logic [CHAN_BITS-1:0]     index;
      logic [PIN_BITS-1:0]      pin_sel;
      logic                     invert;
      logic [PERIOD_BITS-1:0]   period;      // also the value of a register write
      logic [CSR_ADDR_BITS-1:0] reg_index;
      int                       typed_count; // -1: answers come from the model
      change_report_type        typed[3];
   } script_row_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_addr = '0;
   logic [PERIOD_BITS-1:0]    csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      req_tuser = CMD_TICK;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;

   polled_input_change_reporter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Model of the channel table and the full-report timer.
   logic [PIN_BITS-1:0]    chan_pin[CHANNELS];
   logic                   chan_invert[CHANNELS];
   logic [PERIOD_BITS-1:0] chan_period[CHANNELS];
   logic [TIME_BITS-1:0]   chan_due[CHANNELS];
   logic                   chan_level[CHANNELS];
   logic                   chan_known[CHANNELS];
   logic [TIME_BITS-1:0]   full_report_stamp;
   logic                   full_report_due;
   logic [PERIOD_BITS-1:0] model_report_period;
   logic [CNT_BITS-1:0]    model_channel_count;

   change_report_type tick_reports[$];
   change_report_type pending_reports[$];
   script_row_type    script[$];

   int errors = 0;
   int words_sent = 0;
   int ticks_sent = 0;
   int reports_checked = 0;
   int register_writes = 0;
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int hold_requests = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #8_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // Time sum that clamps at the all-ones time.
   function automatic logic [TIME_BITS-1:0] sat_time_sum(logic [TIME_BITS-1:0] a,
                                                        logic [TIME_BITS-1:0] b);
      if (a > TIME_LIMIT - b) return TIME_LIMIT;
      return a + b;
   endfunction

   function automatic change_report_type rpt(int channel, int pin, bit level);
      change_report_type r;
      r.channel = CHAN_BITS'(channel);
      r.pin     = PIN_BITS'(pin);
      r.level   = level;
      r.last    = 1'b0;
      return r;
   endfunction

   // Walk the active channels for one tick and collect its reports.
   function automatic void predict_tick(logic [TIME_BITS-1:0] now, logic [63:0] pins);
      int walk;
      tick_reports.delete();
      if (sat_time_sum(full_report_stamp, TIME_BITS'(model_report_period)) <= now) begin
         full_report_due = 1'b1;
         full_report_stamp = now;
      end
      walk = (model_channel_count > CHANNELS) ? CHANNELS : int'(model_channel_count);
      for (int ch = 0; ch < walk; ch++) begin
         logic lvl;
         if (chan_due[ch] <= now || full_report_due) begin
            if (full_report_due) chan_known[ch] = 1'b0;
            lvl = pins[chan_pin[ch]] ^ chan_invert[ch];
            if (!chan_known[ch] || chan_level[ch] != lvl) begin
               chan_level[ch] = lvl;
               chan_known[ch] = 1'b1;
               tick_reports.push_back(rpt(ch, chan_pin[ch], lvl));
            end
            chan_due[ch] = sat_time_sum(now, TIME_BITS'(chan_period[ch]));
         end
      end
      full_report_due = 1'b0;
      if (tick_reports.size() > 0) tick_reports[tick_reports.size() - 1].last = 1'b1;
   endfunction

   // Script row builders.
   function automatic script_row_type cfg_row(int index, int pin, bit invert,
                                              logic [PERIOD_BITS-1:0] period);
      script_row_type r;
      r = '{kind: ROW_CONFIG, default: '0};
      r.kind        = ROW_CONFIG;
      r.index       = CHAN_BITS'(index);
      r.pin_sel     = PIN_BITS'(pin);
      r.invert      = invert;
      r.period      = period;
      r.typed_count = -1;
      return r;
   endfunction

   function automatic script_row_type tick_row(logic [TIME_BITS-1:0] now, logic [63:0] pins,
                                               int typed_count, change_report_type r0 = '0,
                                               change_report_type r1 = '0,
                                               change_report_type r2 = '0);
      script_row_type r;
      r = '{kind: ROW_TICK, default: '0};
      r.kind        = ROW_TICK;
      r.now         = now;
      r.pins        = pins;
      r.typed_count = typed_count;
      r.typed[0]    = r0;
      r.typed[1]    = r1;
      r.typed[2]    = r2;
      return r;
   endfunction

   function automatic script_row_type csr_row(logic [CSR_ADDR_BITS-1:0] index,
                                              logic [PERIOD_BITS-1:0] value);
      script_row_type r;
      r = '{kind: ROW_CSR, default: '0};
      r.kind        = ROW_CSR;
      r.reg_index   = index;
      r.period      = value;
      r.typed_count = -1;
      return r;
   endfunction

   // Channel period mix: mostly short, so that deadlines keep coming due.
   function automatic logic [PERIOD_BITS-1:0] pick_period();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return PERIOD_BITS'($urandom_range(0, 20));
      if (roll < 7) return PERIOD_BITS'($urandom_range(21, 500));
      if (roll < 9) return PERIOD_BITS'($urandom);
      return ($urandom_range(0, 1) != 0) ? {PERIOD_BITS{1'b1}} : '0;
   endfunction

   // Random word; fields that the command ignores still get random bits.
   function automatic script_row_type random_row(row_kind_type kind,
                                                 logic [TIME_BITS-1:0] now,
                                                 logic [63:0] pins);
      script_row_type r;
      r = '{kind: ROW_TICK, default: '0};
      r.kind        = kind;
      r.now         = now;
      r.pins        = pins;
      r.index       = CHAN_BITS'($urandom_range(0, CHANNELS - 1));
      r.pin_sel     = PIN_BITS'($urandom_range(0, 63));
      r.invert      = 1'($urandom_range(0, 1));
      r.period      = pick_period();
      r.typed_count = -1;
      return r;
   endfunction

   // Next pin word: mostly a few toggled bits, sometimes a fresh pattern.
   function automatic logic [63:0] next_pins(logic [63:0] prev);
      int roll;
      logic [63:0] flips;
      roll = $urandom_range(0, 19);
      flips = '0;
      if (roll < 12) begin
         repeat ($urandom_range(1, 3)) flips[$urandom_range(0, 63)] = 1'b1;
         return prev ^ flips;
      end
      if (roll < 15) return {32'($urandom), 32'($urandom)};
      if (roll < 17) return '0;
      if (roll < 19) return '1;
      return prev;
   endfunction

   // Offer one word, wait for its acceptance and update the model.
   task automatic issue_item(script_row_type row);
      change_report_type r;
      req_tvalid <= 1'b1;
      req_tuser  <= (row.kind == ROW_CONFIG) ? CMD_CONFIG : CMD_TICK;
      req_tdata  <= {4'b0, row.period, row.invert, row.pin_sel, row.index, row.pins, row.now};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (row.kind == ROW_CONFIG) begin
         chan_pin[row.index]    = row.pin_sel;
         chan_invert[row.index] = row.invert;
         chan_period[row.index] = row.period;
         chan_due[row.index]    = '0;
         chan_known[row.index]  = 1'b0;
      end else begin
         ticks_sent++;
         predict_tick(row.now, row.pins);
         if (row.typed_count < 0) begin
            foreach (tick_reports[i]) pending_reports.push_back(tick_reports[i]);
         end else begin
            for (int i = 0; i < row.typed_count; i++) begin
               r = row.typed[i];
               r.last = (i == row.typed_count - 1);
               pending_reports.push_back(r);
            end
         end
      end
      // Random gap before the next word.
      if ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_ADDR_BITS-1:0] index,
                                 logic [PERIOD_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_REPORT_PERIOD) model_report_period = value;
      else model_channel_count = value[CNT_BITS-1:0];
      register_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Compare one accepted report word with the oldest expectation.
   function automatic void compare_report();
      change_report_type exp;
      reports_checked++;
      if (pending_reports.size() == 0) begin
         $error("report with no expectation waiting: channel %0d pin %0d level %0d",
                rsp_tdata[4:0], rsp_tdata[10:5], rsp_tdata[11]);
         errors++;
         return;
      end
      exp = pending_reports.pop_front();
      if (rsp_tdata[4:0] !== exp.channel) begin
         $error("report_channel: expected %0d, actual %0d", exp.channel, rsp_tdata[4:0]);
         errors++;
      end
      if (rsp_tdata[10:5] !== exp.pin) begin
         $error("report_pin: expected %0d, actual %0d", exp.pin, rsp_tdata[10:5]);
         errors++;
      end
      if (rsp_tdata[11] !== exp.level) begin
         $error("report_level: expected %0d, actual %0d", exp.level, rsp_tdata[11]);
         errors++;
      end
      if (rsp_tlast !== exp.last) begin
         $error("last_report: expected %0d, actual %0d", exp.last, rsp_tlast);
         errors++;
      end
   endfunction

   // Report side: checks each word and stalls in bursts or one long hold.
   initial begin : report_sink
      int stall_left;
      int hold_left;
      int holds_served;
      stall_left = 0;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready) compare_report();
            if (hold_left > 0) begin
               hold_left--;
               rsp_tready <= 1'b0;
            end else if (holds_served != hold_requests) begin
               holds_served++;
               hold_left = LONG_HOLD_CYCLES - 1;
               rsp_tready <= 1'b0;
            end else if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
               stall_left = $urandom_range(1, 6) - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Stimulus: reset, directed script, then random phases.
   initial begin : stimulus
      logic [TIME_BITS-1:0]   now_base;
      logic [63:0]            pin_word;
      logic [PERIOD_BITS-1:0] phase_period;
      int                     phase_count;
      int                     roll;

      for (int ch = 0; ch < CHANNELS; ch++) begin
         chan_pin[ch] = '0;
         chan_invert[ch] = 1'b0;
         chan_period[ch] = '0;
         chan_due[ch] = '0;
         chan_level[ch] = 1'b0;
         chan_known[ch] = 1'b0;
      end
      full_report_stamp = '0;
      full_report_due = 1'b1;
      model_report_period = REPORT_PERIOD_RESET;
      model_channel_count = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed script: three entries, first tick after reset reports all,
      // time and period extremes, a tick with nothing to report.
      script.push_back(cfg_row(0, 0, 1'b0, 24'd10));
      script.push_back(cfg_row(1, 63, 1'b1, 24'd0));
      script.push_back(cfg_row(2, 31, 1'b0, {PERIOD_BITS{1'b1}}));
      script.push_back(csr_row(CSR_CHANNEL_COUNT, 24'd3));
      script.push_back(tick_row('0, '0, 3, rpt(0, 0, 0), rpt(1, 63, 1), rpt(2, 31, 0)));
      script.push_back(tick_row(40'd5, '1, -1));
      script.push_back(tick_row(40'd5, '1, -1));
      script.push_back(tick_row(40'd10, 64'd1, -1));
      script.push_back(cfg_row(1, 5, 1'b0, 24'd100));
      script.push_back(tick_row(40'd11, '0, -1));
      script.push_back(tick_row(40'd300, 64'h8000_0000, -1));
      script.push_back(csr_row(CSR_REPORT_PERIOD, '0));
      script.push_back(tick_row(TIME_LIMIT, '0, 3, rpt(0, 0, 0), rpt(1, 5, 0), rpt(2, 31, 0)));
      script.push_back(csr_row(CSR_REPORT_PERIOD, {PERIOD_BITS{1'b1}}));
      script.push_back(tick_row(TIME_LIMIT, '1, 3, rpt(0, 0, 1), rpt(1, 5, 1), rpt(2, 31, 1)));
      script.push_back(tick_row('0, '1, 0));
      script.push_back(csr_row(CSR_CHANNEL_COUNT, '0));
      script.push_back(tick_row(TIME_LIMIT, '1, 0));

      src_idle_pct = 20;
      sink_idle_pct <= 20;
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            settle();
            write_register(script[i].reg_index, script[i].period);
         end else begin
            issue_item(script[i]);
         end
      end

      // Fill every entry while no channel is walked, so none is read unwritten.
      settle();
      for (int ch = 0; ch < CHANNELS; ch++) begin
         script_row_type r;
         r = random_row(ROW_CONFIG, {8'($urandom_range(0, 255)), 32'($urandom)},
                        {32'($urandom), 32'($urandom)});
         r.index = CHAN_BITS'(ch);
         issue_item(r);
      end

      now_base = 40'd1000;
      pin_word = {32'($urandom), 32'($urandom)};
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin phase_period = 24'd300; phase_count = 32; end
            1: begin phase_period = '0; phase_count = 32; end
            2: begin phase_period = {PERIOD_BITS{1'b1}}; phase_count = 63; end
            3: begin phase_period = 24'd40; phase_count = 1; end
            4: begin
               phase_period = PERIOD_BITS'($urandom_range(20, 500));
               phase_count = $urandom_range(1, CHANNELS);
            end
            5: begin phase_period = 24'd150; phase_count = 0; end
            6: begin phase_period = 24'd1; phase_count = 32; end
            7: begin phase_period = PERIOD_BITS'($urandom); phase_count = 7; end
            8: begin phase_period = 24'd25; phase_count = 32; end
            default: begin phase_period = 24'd300; phase_count = 32; end
         endcase
         write_register(CSR_REPORT_PERIOD, phase_period);
         write_register(CSR_CHANNEL_COUNT, PERIOD_BITS'(phase_count));

         // Burst idling on both sides, none in the closing phase.
         if (phase == PHASES - 1) begin
            src_idle_pct = 0;
            sink_idle_pct <= 0;
         end else begin
            roll = $urandom_range(0, 3);
            src_idle_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : (roll == 2) ? 25 : 50;
            roll = $urandom_range(0, 3);
            sink_idle_pct <= (roll == 0) ? 0 : (roll == 1) ? 10 : (roll == 2) ? 25 : 50;
         end

         // Forward ticks are full reports, so a long hold backs up the input.
         if (phase == 1) hold_requests <= hold_requests + 1;

         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            if ($urandom_range(0, 99) < 12) begin
               issue_item(random_row(ROW_CONFIG, {8'($urandom_range(0, 255)), 32'($urandom)},
                                     {32'($urandom), 32'($urandom)}));
            end else begin
               roll = $urandom_range(0, 19);
               if (roll < 14) now_base = now_base + TIME_BITS'($urandom_range(0, 30));
               else if (roll < 17) now_base = now_base + TIME_BITS'($urandom_range(31, 1000));
               else if (roll == 17) now_base = {8'($urandom_range(0, 255)), 32'($urandom)};
               else if (roll == 18) now_base = TIME_LIMIT - TIME_BITS'($urandom_range(0, 50));
               pin_word = next_pins(pin_word);
               issue_item(random_row(ROW_TICK, now_base, pin_word));
            end
         end
      end

      settle();
      $display("Run covered %0d words (%0d ticks) and %0d register writes.",
               words_sent, ticks_sent, register_writes);
      $display("Reports checked: %0d, mismatches: %0d.", reports_checked, errors);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
